[src/tbcd_pkg.sv]
package tbcd_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INVAL  = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_RUN    = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND  = 2'd1;
  localparam logic [1:0] STATUS_THROTTLED = 2'd2;

  localparam int unsigned AddrW  = 36;
  localparam int unsigned LenW   = 13;
  localparam int unsigned CountW = 11;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ThrW   = 4;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned HintW  = 6;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LATCH = 4'd1,
    OP_LOOK  = 4'd2,
    OP_INVAL = 4'd3,
    OP_VICT  = 4'd4,
    OP_WRITE = 4'd5,
    OP_BUB   = 4'd6
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       throttled;
    logic       idx_last;
    logic       look_hit;
    logic       short_blk;
    logic       bub_stop;
  } ctl_sts_t;

endpackage

[src/tbcd_dp.sv]
module tbcd_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tbcd_pkg::ctl_cmd_t                cmd_i,
  output tbcd_pkg::ctl_sts_t                sts_o,
  input  logic [1:0]                        action_i,
  input  logic [tbcd_pkg::AddrW-1:0]        addr_i,
  input  logic [tbcd_pkg::LenW-1:0]         span_len_i,
  input  logic [tbcd_pkg::AddrW-1:0]        end_addr_i,
  input  logic [tbcd_pkg::CountW-1:0]       instr_count_i,
  input  logic [4:0]                        hint_reg_i,
  input  logic                              hint_write_i,
  input  logic [tbcd_pkg::SlotW-1:0]        run_slot_i,
  output logic                              hit_o,
  output logic [tbcd_pkg::SlotW-1:0]        found_slot_o,
  output logic [tbcd_pkg::CountW-1:0]       block_count_o,
  output logic [4:0]                        out_hint_reg_o,
  output logic                              out_hint_write_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);
  localparam int unsigned AW = tbcd_pkg::AddrW;

  // entry store
  logic [AW-1:0]                    start_q [ENTRIES];
  logic [AW-1:0]                    end_q   [ENTRIES];
  logic [ENTRIES-1:0]               valid_q;
  logic [tbcd_pkg::TimeW-1:0]       time_q  [ENTRIES];
  logic [tbcd_pkg::CountW-1:0]      count_q [ENTRIES];
  logic [tbcd_pkg::HintW-1:0]       hint_q  [ENTRIES];

  logic [tbcd_pkg::TimeW-1:0]       tick_q, oldest_q;
  logic [tbcd_pkg::ThrW-1:0]        thr_q, thr_d;
  logic [IW-1:0]                    idx_q, victim_q, pos_q;

  // latched word
  logic [AW-1:0]                    addr_q, eaddr_q;
  logic [AW:0]                      last_q;
  logic [tbcd_pkg::CountW-1:0]      icnt_q;
  logic [tbcd_pkg::HintW-1:0]       ihint_q;

  // pending result
  logic                             res_hit_q;
  logic [tbcd_pkg::SlotW-1:0]       res_slot_q;
  logic [tbcd_pkg::CountW-1:0]      res_cnt_q;
  logic [tbcd_pkg::HintW-1:0]       res_hint_q;
  logic [1:0]                       res_status_q;

  logic [tbcd_pkg::LenW-1:0]        len_eff;
  logic [AW:0]                      last_d, addr_x, s_x, e_x;
  logic                             overlap, vict_take, run_reject;
  logic [IW-1:0]                    run_idx, pos_m1, pos_p1, pos_j;
  logic                             go_lo, go_hi;

  // input side decode
  always_comb begin
    len_eff    = (span_len_i == '0) ? tbcd_pkg::LenW'(1) : span_len_i;
    last_d     = {1'b0, addr_i} + (AW+1)'(len_eff) - (AW+1)'(1);
    run_reject = 32'(run_slot_i) >= ENTRIES;
    run_idx    = IW'(run_slot_i);
    thr_d      = thr_q + tbcd_pkg::ThrW'(1);
  end

  // scan compare on the entry at the index
  always_comb begin
    addr_x    = {1'b0, addr_q};
    s_x       = {1'b0, start_q[idx_q]};
    e_x       = {1'b0, end_q[idx_q]};
    overlap   = (addr_x >= s_x && addr_x <= e_x) || (last_q >= s_x && last_q <= e_x) ||
                (addr_x < s_x && last_q > e_x);
    vict_take = (idx_q == '0) || (time_q[idx_q] < oldest_q) || !valid_q[idx_q];
  end

  // neighbour compare for the sorting pass
  always_comb begin
    pos_m1 = (pos_q == '0) ? pos_q : pos_q - IW'(1);
    pos_p1 = (pos_q == LastIdx) ? pos_q : pos_q + IW'(1);
    go_lo  = (pos_q != '0) && (start_q[pos_q] < start_q[pos_m1]);
    go_hi  = (pos_q != LastIdx) && (start_q[pos_q] > start_q[pos_p1]);
    pos_j  = go_hi ? pos_p1 : pos_m1;
  end

  always_comb begin
    sts_o.action     = action_i;
    sts_o.throttled  = thr_d != '0;
    sts_o.idx_last   = idx_q == LastIdx;
    sts_o.look_hit   = valid_q[idx_q] && (start_q[idx_q] == addr_q);
    sts_o.short_blk  = icnt_q <= tbcd_pkg::CountW'(1);
    sts_o.bub_stop   = !(go_lo || go_hi);
  end

  // control state and reset-cleared entry fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      tick_q   <= '0;
      idx_q    <= '0;
      victim_q <= '0;
      oldest_q <= '0;
      pos_q    <= '0;
      valid_q  <= '0;
      for (int k = 0; k < ENTRIES; k++) begin
        start_q[k] <= '0;
        end_q[k]   <= '0;
        time_q[k]  <= '0;
      end
    end else begin
      case (cmd_i.op)
        tbcd_pkg::OP_LATCH: begin
          idx_q <= '0;
          if (action_i == tbcd_pkg::ACT_INSERT) begin
            thr_q <= thr_d;
            if (thr_d == '0) tick_q <= tick_q + 32'd1;
          end
          if (action_i == tbcd_pkg::ACT_RUN && !run_reject) begin
            tick_q          <= tick_q + 32'd1;
            time_q[run_idx] <= tick_q + 32'd1;
          end
        end
        tbcd_pkg::OP_LOOK: idx_q <= idx_q + IW'(1);
        tbcd_pkg::OP_INVAL: begin
          idx_q <= idx_q + IW'(1);
          if (overlap) valid_q[idx_q] <= 1'b0;
        end
        tbcd_pkg::OP_VICT: begin
          idx_q <= idx_q + IW'(1);
          if (vict_take) begin
            victim_q <= idx_q;
            oldest_q <= time_q[idx_q];
          end
        end
        tbcd_pkg::OP_WRITE: begin
          pos_q <= victim_q;
          if (icnt_q <= tbcd_pkg::CountW'(1)) begin
            valid_q[victim_q] <= 1'b0;
          end else begin
            valid_q[victim_q] <= 1'b1;
            time_q[victim_q]  <= tick_q;
            start_q[victim_q] <= addr_q;
            end_q[victim_q]   <= eaddr_q;
          end
        end
        tbcd_pkg::OP_BUB: begin
          if (go_lo || go_hi) begin
            start_q[pos_q] <= start_q[pos_j];
            start_q[pos_j] <= start_q[pos_q];
            end_q[pos_q]   <= end_q[pos_j];
            end_q[pos_j]   <= end_q[pos_q];
            time_q[pos_q]  <= time_q[pos_j];
            time_q[pos_j]  <= time_q[pos_q];
            valid_q[pos_q] <= valid_q[pos_j];
            valid_q[pos_j] <= valid_q[pos_q];
            pos_q          <= pos_j;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: latched word, count and hint store, result and output words
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tbcd_pkg::OP_LATCH: begin
        addr_q     <= addr_i;
        eaddr_q    <= end_addr_i;
        last_q     <= last_d;
        icnt_q     <= instr_count_i;
        ihint_q    <= {hint_write_i, hint_reg_i};
        res_hit_q  <= 1'b0;
        res_slot_q <= (action_i == tbcd_pkg::ACT_RUN) ? run_slot_i : '0;
        if (action_i == tbcd_pkg::ACT_INSERT && thr_d != '0) begin
          res_status_q <= tbcd_pkg::STATUS_THROTTLED;
        end else if (action_i == tbcd_pkg::ACT_RUN && run_reject) begin
          res_status_q <= tbcd_pkg::STATUS_NOTFOUND;
        end else begin
          res_status_q <= tbcd_pkg::STATUS_DONE;
        end
        if (action_i == tbcd_pkg::ACT_RUN && !run_reject) begin
          res_cnt_q  <= count_q[run_idx];
          res_hint_q <= hint_q[run_idx];
        end else begin
          res_cnt_q  <= '0;
          res_hint_q <= '0;
        end
      end
      tbcd_pkg::OP_LOOK: begin
        if (valid_q[idx_q] && start_q[idx_q] == addr_q) begin
          res_hit_q  <= 1'b1;
          res_slot_q <= tbcd_pkg::SlotW'(idx_q);
          res_cnt_q  <= count_q[idx_q];
          res_hint_q <= hint_q[idx_q];
        end else if (idx_q == LastIdx) begin
          res_status_q <= tbcd_pkg::STATUS_NOTFOUND;
        end
      end
      tbcd_pkg::OP_WRITE: begin
        if (icnt_q <= tbcd_pkg::CountW'(1)) begin
          res_status_q <= tbcd_pkg::STATUS_NOTFOUND;
        end else begin
          count_q[victim_q] <= icnt_q;
          hint_q[victim_q]  <= ihint_q;
        end
      end
      tbcd_pkg::OP_BUB: begin
        if (go_lo || go_hi) begin
          count_q[pos_q] <= count_q[pos_j];
          count_q[pos_j] <= count_q[pos_q];
          hint_q[pos_q]  <= hint_q[pos_j];
          hint_q[pos_j]  <= hint_q[pos_q];
        end else begin
          res_hit_q  <= 1'b1;
          res_slot_q <= tbcd_pkg::SlotW'(pos_q);
          res_cnt_q  <= icnt_q;
          res_hint_q <= ihint_q;
        end
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      hit_o            <= res_hit_q;
      found_slot_o     <= res_slot_q;
      block_count_o    <= res_cnt_q;
      out_hint_reg_o   <= res_hint_q[4:0];
      out_hint_write_o <= res_hint_q[5];
      status_o         <= res_status_q;
    end
  end

endmodule

[src/tbcd_ctrl.sv]
module tbcd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tbcd_pkg::ctl_sts_t sts_i,
  output tbcd_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOOK  = 7'b0000010,
    ST_INVAL = 7'b0000100,
    ST_VICT  = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_BUB   = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  // sequencing
  always_comb begin
    state_d          = state_q;
    cmd_o.op         = tbcd_pkg::OP_NONE;
    cmd_o.load_out   = 1'b0;
    out_valid_d      = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = tbcd_pkg::OP_LATCH;
          unique case (sts_i.action)
            tbcd_pkg::ACT_LOOKUP: state_d = ST_LOOK;
            tbcd_pkg::ACT_INVAL:  state_d = ST_INVAL;
            tbcd_pkg::ACT_INSERT: state_d = sts_i.throttled ? ST_RESP : ST_VICT;
            default:              state_d = ST_RESP;
          endcase
        end
      end
      ST_LOOK: begin
        cmd_o.op = tbcd_pkg::OP_LOOK;
        if (sts_i.look_hit || sts_i.idx_last) state_d = ST_RESP;
      end
      ST_INVAL: begin
        cmd_o.op = tbcd_pkg::OP_INVAL;
        if (sts_i.idx_last) state_d = ST_RESP;
      end
      ST_VICT: begin
        cmd_o.op = tbcd_pkg::OP_VICT;
        if (sts_i.idx_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.op = tbcd_pkg::OP_WRITE;
        state_d  = sts_i.short_blk ? ST_RESP : ST_BUB;
      end
      ST_BUB: begin
        cmd_o.op = tbcd_pkg::OP_BUB;
        if (sts_i.bub_stop) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/translation_block_cache_directory.sv]
// Sequence: run and throttled insert go straight to the output register; lookup scans the
// entries until the match or the last entry; invalidate scans every entry; short insert scans
// every entry for a victim and clears its slot; insert writes the victim, then swaps neighbours
// until the order holds. Each scan takes one entry per cycle.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset: asynchronous, clears all valid bits, times, starts, ends and both counters at once.
module translation_block_cache_directory #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [35:0] addr_i,
  input  logic [12:0] span_len_i,
  input  logic [35:0] end_addr_i,
  input  logic [10:0] instr_count_i,
  input  logic [4:0]  hint_reg_i,
  input  logic        hint_write_i,
  input  logic [3:0]  run_slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [3:0]  found_slot_o,
  output logic [10:0] block_count_o,
  output logic [4:0]  out_hint_reg_o,
  output logic        out_hint_write_o,
  output logic [1:0]  status_o
);

  tbcd_pkg::ctl_cmd_t cmd;
  tbcd_pkg::ctl_sts_t sts;

  tbcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tbcd_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .addr_i           (addr_i),
    .span_len_i       (span_len_i),
    .end_addr_i       (end_addr_i),
    .instr_count_i    (instr_count_i),
    .hint_reg_i       (hint_reg_i),
    .hint_write_i     (hint_write_i),
    .run_slot_i       (run_slot_i),
    .hit_o            (hit_o),
    .found_slot_o     (found_slot_o),
    .block_count_o    (block_count_o),
    .out_hint_reg_o   (out_hint_reg_o),
    .out_hint_write_o (out_hint_write_o),
    .status_o         (status_o)
  );

endmodule
